@@ rtl/sdaf_pkg.sv @@
// Shared types, character codes and conversion helpers for the signed decimal formatter.
// Used by rtl/signed_decimal_ascii_formatter.sv; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package sdaf_pkg;

   localparam int BIN_W       = 32;
   localparam int NUM_DIGITS  = 10;
   localparam int BCD_W       = 4 * NUM_DIGITS;
   localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
   localparam int DAB_STEPS   = 8;
   localparam int DAB_STAGES  = BIN_W / DAB_STEPS;
   localparam int NUM_STAGES  = 1 + DAB_STAGES;
   localparam int CHAR_W      = 7;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;
   localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CH_CR    = 7'h0D;
   localparam logic [CHAR_W-1:0] CH_LF    = 7'h0A;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIGN,
      ST_DIGIT,
      ST_CR,
      ST_LF
   } state_type;

   typedef struct packed {
      logic             neg;
      logic             nl;
      logic [BCD_W-1:0] bcd;
      logic [BIN_W-1:0] bin;
   } stage_type;

   // Several shift-and-add-three steps of the binary to BCD conversion.
   function automatic stage_type dabble_steps(input stage_type s);
      stage_type  r;
      logic [3:0] d;
      r = s;
      for (int i = 0; i < DAB_STEPS; i++) begin
         for (int j = 0; j < NUM_DIGITS; j++) begin
            d = r.bcd[j*4 +: 4];
            if (d >= 4'd5) begin
               r.bcd[j*4 +: 4] = d + 4'd3;
            end
         end
         {r.bcd, r.bin} = {r.bcd[BCD_W-2:0], r.bin, 1'b0};
      end
      return r;
   endfunction

   // Index of the most significant nonzero digit, or zero when all digits are zero.
   function automatic logic [DIGIT_IDX_W-1:0] top_digit(input logic [BCD_W-1:0] bcd);
      logic [DIGIT_IDX_W-1:0] idx;
      idx = '0;
      for (int j = 0; j < NUM_DIGITS; j++) begin
         if (bcd[j*4 +: 4] != 4'd0) begin
            idx = DIGIT_IDX_W'(j);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

@@ rtl/signed_decimal_ascii_formatter.sv @@
// Top level of the signed decimal formatter: conversion pipeline and character serializer.
// Depends on rtl/sdaf_pkg.sv for types, character codes and conversion functions.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports             Contents
// req       in         req_t*            32-bit signed value, newline flag
// rsp       out        rsp_t*            one ASCII character, last of run
//
// A value passes one input register and four conversion stages, then waits in the last
// stage while the serializer is busy. The serializer loads it in IDLE and then emits one
// character per cycle while rsp is not stalled: 1 to 13 characters per value, 13 at most
// for a negative ten-digit value with newline. Reset clears all valid bits and the
// serializer state.
// A stall on rsp holds the output register; the pipeline fills and then drops req_tready.

module signed_decimal_ascii_formatter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic        req_tuser,   // [0] add_newline
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [7:0]  rsp_tdata,   // [6:0] character, [7] zero fill
   output      logic        rsp_tlast
);

   localparam int LAST = sdaf_pkg::NUM_STAGES - 1;

   sdaf_pkg::stage_type pipe_ff [sdaf_pkg::NUM_STAGES];
   sdaf_pkg::stage_type pipe_in [sdaf_pkg::NUM_STAGES];
   logic                valid_ff [sdaf_pkg::NUM_STAGES];
   logic                stage_ready [sdaf_pkg::NUM_STAGES];

   sdaf_pkg::state_type                st_ff, st_in;
   logic [sdaf_pkg::DIGIT_IDX_W-1:0]   idx_ff, idx_in;
   logic [sdaf_pkg::BCD_W-1:0]         bcd_ff, bcd_in;
   logic                               nl_ff, nl_in;
   logic                               load;
   logic                               emit;
   logic [3:0]                         cur_digit;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [sdaf_pkg::CHAR_W-1:0]        rsp_char_ff, rsp_char_in;
   logic                               rsp_last_ff, rsp_last_in;
   logic [sdaf_pkg::CHAR_W-1:0]        char_out;
   logic                               last_out;

   assign load = (st_ff == sdaf_pkg::ST_IDLE) && valid_ff[LAST];

   always_comb begin
      stage_ready[LAST] = !valid_ff[LAST] || load;
      for (int k = LAST - 1; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   assign req_tready = stage_ready[0];

   always_comb begin
      pipe_in[0].neg = req_tdata[31];
      pipe_in[0].nl  = req_tuser;
      pipe_in[0].bcd = '0;
      pipe_in[0].bin = req_tdata[31] ? (32'd0 - req_tdata) : req_tdata;
      for (int k = 1; k < sdaf_pkg::NUM_STAGES; k++) begin
         pipe_in[k] = sdaf_pkg::dabble_steps(pipe_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < sdaf_pkg::NUM_STAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         if (stage_ready[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < sdaf_pkg::NUM_STAGES; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < sdaf_pkg::NUM_STAGES; k++) begin
         if (stage_ready[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   assign emit      = (st_ff != sdaf_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign cur_digit = bcd_ff[{idx_ff, 2'b00} +: 4];

   // Next state of the serializer.
   always_comb begin
      st_in  = st_ff;
      idx_in = idx_ff;
      bcd_in = bcd_ff;
      nl_in  = nl_ff;
      unique case (st_ff)
         sdaf_pkg::ST_IDLE: begin
            if (load) begin
               st_in  = pipe_ff[LAST].neg ? sdaf_pkg::ST_SIGN : sdaf_pkg::ST_DIGIT;
               idx_in = sdaf_pkg::top_digit(pipe_ff[LAST].bcd);
               bcd_in = pipe_ff[LAST].bcd;
               nl_in  = pipe_ff[LAST].nl;
            end
         end
         sdaf_pkg::ST_SIGN: begin
            if (emit) begin
               st_in = sdaf_pkg::ST_DIGIT;
            end
         end
         sdaf_pkg::ST_DIGIT: begin
            if (emit) begin
               if (idx_ff == '0) begin
                  st_in = nl_ff ? sdaf_pkg::ST_CR : sdaf_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         sdaf_pkg::ST_CR: begin
            if (emit) begin
               st_in = sdaf_pkg::ST_LF;
            end
         end
         sdaf_pkg::ST_LF: begin
            if (emit) begin
               st_in = sdaf_pkg::ST_IDLE;
            end
         end
         default: begin
            st_in = sdaf_pkg::ST_IDLE;
         end
      endcase
   end

   // Character and last flag for the current serializer state.
   always_comb begin
      char_out = sdaf_pkg::CH_ZERO;
      last_out = 1'b0;
      unique case (st_ff)
         sdaf_pkg::ST_IDLE: begin
            char_out = sdaf_pkg::CH_ZERO;
         end
         sdaf_pkg::ST_SIGN: begin
            char_out = sdaf_pkg::CH_MINUS;
         end
         sdaf_pkg::ST_DIGIT: begin
            char_out = sdaf_pkg::CH_ZERO + {3'b000, cur_digit};
            last_out = (idx_ff == '0) && !nl_ff;
         end
         sdaf_pkg::ST_CR: begin
            char_out = sdaf_pkg::CH_CR;
         end
         sdaf_pkg::ST_LF: begin
            char_out = sdaf_pkg::CH_LF;
            last_out = 1'b1;
         end
         default: begin
            char_out = sdaf_pkg::CH_ZERO;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = char_out;
         rsp_last_in  = last_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= sdaf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      bcd_ff      <= bcd_in;
      nl_ff       <= nl_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

   // A digit leaving the serializer is always a decimal digit character.
   assert property (@(posedge clock) disable iff (reset)
      emit && (st_ff == sdaf_pkg::ST_DIGIT) |=>
         (rsp_tdata[6:0] >= sdaf_pkg::CH_ZERO) && (rsp_tdata[6:0] <= sdaf_pkg::CH_NINE))
      else $error("serializer emitted a non-digit character from a BCD digit");

   // The line feed ends the run and frees the serializer.
   assert property (@(posedge clock) disable iff (reset)
      emit && (st_ff == sdaf_pkg::ST_LF) |=> (st_ff == sdaf_pkg::ST_IDLE) && rsp_tlast)
      else $error("line feed did not close the run");

   // A converted value waiting for the serializer is held unchanged.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST] && !load |=> valid_ff[LAST] && $stable(pipe_ff[LAST]))
      else $error("stalled pipeline output was lost or changed");

   // The serializer only leaves idle by taking a converted value.
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == sdaf_pkg::ST_IDLE) && !valid_ff[LAST] |=> (st_ff == sdaf_pkg::ST_IDLE))
      else $error("serializer started without a converted value");

endmodule

`default_nettype wire

@@ bench/signed_decimal_ascii_formatter_tb.sv @@
// Self-checking bench for signed_decimal_ascii_formatter: drives signed values with newline
// flags and checks every ASCII character and last flag against its own decimal formatter.
// Depends on rtl/sdaf_pkg.sv and rtl/signed_decimal_ascii_formatter.sv.
`timescale 1ns / 1ps

module signed_decimal_ascii_formatter_tb;

   typedef struct {
      logic [31:0] value;
      logic        add_newline;
      bit          pause_before;
   } value_item_type;

   typedef struct {
      logic [sdaf_pkg::CHAR_W-1:0] ch;
      logic                        last;
   } char_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] value
   logic        req_tuser = 1'b0; // [0] add_newline
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [6:0] character, [7] zero fill
   logic        rsp_tlast;

   value_item_type pending_values[$];
   value_item_type current_value;
   char_beat_type  expected_chars[$];

   int total_values = 0;
   int values_taken = 0;
   int values_sent = 0;
   int chars_checked = 0;
   int negative_runs = 0;
   int newline_runs = 0;
   int longest_runs = 0;
   int errors = 0;
   int stall_trigger = 0;
   int stall_left = 0;
   bit stall_done = 1'b0;

   signed_decimal_ascii_formatter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int sender_idle_pct();
      if (values_taken < total_values / 3) begin
         return 9;
      end else if (values_taken < (2 * total_values) / 3) begin
         return 70;
      end
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (values_taken < total_values / 3) begin
         return 70;
      end else if (values_taken < (2 * total_values) / 3) begin
         return 9;
      end
      return 0;
   endfunction

   function automatic void format_decimal(input logic [31:0] value, input logic add_newline);
      logic [31:0]       magnitude;
      logic [3:0]        digit_stack[10];
      int                num_digits;
      int                run_len;
      char_beat_type     beat;
      magnitude  = value[31] ? (32'd0 - value) : value;
      num_digits = 0;
      run_len    = 0;
      do begin
         digit_stack[num_digits] = 4'(magnitude % 32'd10);
         magnitude = magnitude / 32'd10;
         num_digits++;
      end while (magnitude != 32'd0 && num_digits < 10);
      beat.last = 1'b0;
      if (value[31]) begin
         beat.ch = sdaf_pkg::CH_MINUS;
         expected_chars.push_back(beat);
         run_len++;
         negative_runs++;
      end
      for (int k = num_digits - 1; k >= 0; k--) begin
         beat.ch = sdaf_pkg::CH_ZERO + sdaf_pkg::CHAR_W'(digit_stack[k]);
         expected_chars.push_back(beat);
         run_len++;
      end
      if (add_newline) begin
         beat.ch = sdaf_pkg::CH_CR;
         expected_chars.push_back(beat);
         beat.ch = sdaf_pkg::CH_LF;
         expected_chars.push_back(beat);
         run_len += 2;
         newline_runs++;
      end
      expected_chars[expected_chars.size() - 1].last = 1'b1;
      if (run_len == 13) begin
         longest_runs++;
      end
   endfunction

   task automatic queue_value(input longint value, input bit add_newline, input bit pause);
      value_item_type item;
      item.value        = value[31:0];
      item.add_newline  = add_newline;
      item.pause_before = pause;
      pending_values.push_back(item);
   endtask

   function automatic longint power_of_ten(input int exponent);
      longint p;
      p = 1;
      for (int i = 0; i < exponent; i++) begin
         p = p * 10;
      end
      return p;
   endfunction

   task automatic note_error(input string what, input logic [7:0] want_data,
                             input logic want_last);
      errors++;
      if (errors <= 10) begin
         $display("%s at character %0d: expected data %h last %b, got data %h last %b",
                  what, chars_checked, want_data, want_last, rsp_tdata, rsp_tlast);
      end
   endtask

   always @(posedge clock) begin : value_driver
      bit holding;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         holding = req_tvalid;
         if (req_tvalid && req_tready) begin
            format_decimal(current_value.value, current_value.add_newline);
            values_sent++;
            holding = 1'b0;
         end
         if (!holding && pending_values.size() > 0) begin
            if (!(pending_values[0].pause_before && expected_chars.size() != 0) &&
                $urandom_range(0, 99) >= sender_idle_pct()) begin
               current_value = pending_values.pop_front();
               req_tdata <= current_value.value;
               req_tuser <= current_value.add_newline;
               values_taken++;
               holding = 1'b1;
            end
         end
         req_tvalid <= holding;
      end
   end

   always @(posedge clock) begin : char_monitor
      char_beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               note_error("Unexpected character", 8'h00, 1'b0);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_tdata !== {1'b0, want.ch} || rsp_tlast !== want.last) begin
                  note_error("Character mismatch", {1'b0, want.ch}, want.last);
               end
            end
            chars_checked++;
         end
         rsp_tready <= (stall_left > 0) ? 1'b0 : ($urandom_range(0, 99) >= receiver_idle_pct());
      end
   end

   always @(posedge clock) begin : receiver_stall
      if (reset) begin
         stall_left <= 0;
      end else if (!stall_done && values_taken >= stall_trigger) begin
         stall_left <= 400;
         stall_done <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end
   end

   initial begin : stimulus
      longint value;
      longint span;
      int     sel;
      int     exponent;
      queue_value(0, 1'b0, 1'b0);
      queue_value(0, 1'b1, 1'b0);
      queue_value(1, 1'b0, 1'b0);
      queue_value(-1, 1'b1, 1'b0);
      queue_value(9, 1'b1, 1'b0);
      queue_value(10, 1'b0, 1'b0);
      queue_value(-9, 1'b0, 1'b0);
      queue_value(-10, 1'b1, 1'b0);
      queue_value(99, 1'b0, 1'b0);
      queue_value(100, 1'b1, 1'b0);
      queue_value(2147483647, 1'b0, 1'b0);
      queue_value(2147483647, 1'b1, 1'b0);
      queue_value(-2147483648, 1'b0, 1'b0);
      queue_value(-2147483648, 1'b1, 1'b0);
      queue_value(-2147483647, 1'b1, 1'b0);
      queue_value(1000000000, 1'b0, 1'b0);
      queue_value(999999999, 1'b1, 1'b0);
      queue_value(-999999999, 1'b0, 1'b0);
      queue_value(-1000000000, 1'b1, 1'b0);
      queue_value(2000000000, 1'b0, 1'b0);
      queue_value(1234567890, 1'b1, 1'b0);
      queue_value(-2004318072, 1'b0, 1'b0);
      queue_value(32'h5555_5555, 1'b1, 1'b0);
      queue_value(-32'sh2AAA_AAAB, 1'b0, 1'b0);
      for (int n = 0; n < 436; n++) begin
         sel = $urandom_range(0, 9);
         if (sel <= 2) begin
            value = longint'($signed($urandom()));
         end else if (sel <= 4) begin
            value = longint'($urandom_range(0, 200)) - 100;
         end else if (sel <= 6) begin
            exponent = $urandom_range(0, 9);
            value = power_of_ten(exponent) + longint'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1) == 1) begin
               value = -value;
            end
         end else if (sel == 7) begin
            value = ($urandom_range(0, 1) == 1) ? 2147483647 - longint'($urandom_range(0, 3))
                                               : -2147483648 + longint'($urandom_range(0, 3));
         end else begin
            exponent = $urandom_range(1, 9);
            span = power_of_ten(exponent);
            value = longint'({$urandom(), $urandom()} % 64'(span));
            if ($urandom_range(0, 1) == 1) begin
               value = -value;
            end
         end
         queue_value(value, 1'($urandom_range(0, 1)), (n == 0) || ($urandom_range(0, 49) == 0));
      end
      total_values  = pending_values.size();
      stall_trigger = (5 * total_values) / 6;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (values_sent < total_values || expected_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (expected_chars.size() != 0) begin
         errors++;
         $display("%0d expected characters never arrived", expected_chars.size());
      end

      $display("Sent %0d values (%0d negative, %0d with newline, %0d of full length)",
               values_sent, negative_runs, newline_runs, longest_runs);
      $display("Checked %0d characters under three idle mixes and one long output stall",
               chars_checked);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d errors", errors);
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #1000000;
      $display("Timeout with %0d values pending and %0d characters expected",
               pending_values.size(), expected_chars.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
